// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/fmt_pkg.sv -----
// ----------------------------------------------------------------------------
// fmt_pkg
// Shared types and constants of the fuzzy membership table.
// ----------------------------------------------------------------------------
package fmt_pkg;

  localparam int PT_W       = 8;
  localparam int VAL_W      = 9;
  localparam int KIND_W     = 3;
  localparam int STAT_W     = 2;
  localparam int TI_W       = 2;
  localparam int IN_DATA_W  = 56;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 16;

  // membership of 1.0
  localparam logic [VAL_W-1:0] ONE = 9'd256;

  // item modes
  localparam logic MODE_QUERY = 1'b0;
  localparam logic MODE_ADD   = 1'b1;

  // term kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SINGLE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RAMP   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TRI    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TRAP   = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_QUERY = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ADDED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIVR_GO,
    ST_DIVR_WAIT,
    ST_DIVF_GO,
    ST_DIVF_WAIT,
    ST_SWEEP,
    ST_ADD_RES,
    ST_FULL_RES,
    ST_Q_RD,
    ST_Q_OUT
  } fsm_state_t;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              div_start;
    logic              div_fall;
    logic              div_cap_rise;
    logic              div_cap_fall;
    logic              sweep_init;
    logic              sweep_step;
    logic              row_commit;
    logic              rd_issue;
    logic              k_step;
    logic              out_load;
    logic [STAT_W-1:0] out_status;
  } fmt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic mode;
    logic kind_ok;
    logic full;
    logic div_done;
    logic x_last;
    logic k_last;
    logic out_free;
  } fmt_sts_t;

endpackage

// ----- rtl/fmt_ram.sv -----
// ----------------------------------------------------------------------------
// fmt_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fmt_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/fmt_div.sv -----
// ----------------------------------------------------------------------------
// fmt_div
// Restoring divider: 256 / den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fmt_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [fmt_pkg::PT_W-1:0]   den,
  output logic                       done,
  output logic [fmt_pkg::VAL_W-1:0]  quo,
  output logic [fmt_pkg::PT_W-1:0]   rmd
);

  localparam logic [3:0] LAST = 4'(fmt_pkg::VAL_W - 1);

  logic                      busy;
  logic [3:0]                cnt;
  logic [fmt_pkg::PT_W-1:0]  dv;
  logic                      dbit;
  logic [fmt_pkg::VAL_W-1:0] rem_sh;
  logic [fmt_pkg::VAL_W-1:0] diff;
  logic                      ge;

  // one restoring step
  always_comb begin
    dbit   = fmt_pkg::ONE[LAST - cnt];
    rem_sh = {rmd, dbit};
    diff   = rem_sh - {1'b0, dv};
    ge     = rem_sh >= {1'b0, dv};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 4'd1;
      end
    end
  end

  // quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      dv  <= den;
      rmd <= '0;
      quo <= '0;
    end else if (busy) begin
      rmd <= ge ? diff[fmt_pkg::PT_W-1:0] : rem_sh[fmt_pkg::PT_W-1:0];
      quo <= {quo[fmt_pkg::VAL_W-2:0], ge};
    end
  end

endmodule

// ----- rtl/fmt_datapath.sv -----
// ----------------------------------------------------------------------------
// fmt_datapath
// Item registers, row rasterizer, membership RAM and result register.
// ----------------------------------------------------------------------------
module fmt_datapath #(
  parameter int TERMS    = 4,
  parameter int UNIVERSE = 256
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [fmt_pkg::IN_DATA_W-1:0]     in_data,
  input  logic [fmt_pkg::IN_USER_W-1:0]     in_user,
  input  fmt_pkg::fmt_cmd_t                 cmd,
  output fmt_pkg::fmt_sts_t                 sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fmt_pkg::OUT_DATA_W-1:0]    out_data,
  output logic                              out_last
);

  localparam int PW    = fmt_pkg::PT_W;
  localparam int VW    = fmt_pkg::VAL_W;
  localparam int SPAN  = (UNIVERSE < 256) ? UNIVERSE : 256;
  localparam int XW    = $clog2(SPAN);
  localparam int RW    = (TERMS > 1) ? $clog2(TERMS) : 1;
  localparam int NRW   = $clog2(TERMS + 1);
  localparam int DEPTH = TERMS * (2 ** XW);
  localparam int AW    = $clog2(DEPTH);

  // latched item
  logic                        mode;
  logic [fmt_pkg::KIND_W-1:0]  kind;
  logic [PW-1:0]               pa, pb, pc, pd, qx;
  logic [VW-1:0]               ht;

  // table bookkeeping
  logic [NRW-1:0]              next_row;
  logic [TERMS-1:0]            row_valid;
  logic [RW-1:0]               row;
  logic [RW-1:0]               k;

  // term shape
  logic [PW-1:0]               lo, hi, brk1, brk2, pivot, rise_den, fall_den;
  logic                        rise_en, flat_en, single;
  logic [VW-1:0]               hsat;

  // segment steps from the divider
  logic [VW-1:0]               rise_q, fall_q;
  logic [PW-1:0]               rise_r, fall_r;
  logic                        div_done;
  logic [VW-1:0]               div_quo;
  logic [PW-1:0]               div_rmd;

  // sweep state
  logic [XW-1:0]               x;
  logic [VW-1:0]               rq, fq;
  logic [PW-1:0]               rr, fr;
  logic [PW-1:0]               x8;
  logic [PW:0]                 xn;
  logic [PW:0]                 rsum, fsum;
  logic [VW-1:0]               val;

  // memory ports
  logic [RW+XW-1:0]            wcat, rcat;
  logic [VW-1:0]               rdata;
  logic                        qx_in;

  // result register
  logic [fmt_pkg::TI_W-1:0]    o_ti;
  logic [VW-1:0]               o_mem;
  logic [fmt_pkg::STAT_W-1:0]  o_st;
  logic                        o_last;

  assign row = next_row[RW-1:0];

  // capture item on accept
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode <= in_user[0];
      kind <= in_user[3:1];
      pa   <= in_data[7:0];
      pb   <= in_data[15:8];
      pc   <= in_data[23:16];
      pd   <= in_data[31:24];
      ht   <= in_data[40:32];
      qx   <= in_data[48:41];
    end
  end

  // decode term shape: rising part, plateau, falling part
  always_comb begin
    lo       = pa;
    hi       = pa;
    brk1     = pb;
    brk2     = pc;
    pivot    = pb;
    rise_den = pb - pa;
    fall_den = pc - pb;
    rise_en  = 1'b0;
    flat_en  = 1'b0;
    single   = 1'b0;
    case (kind)
      fmt_pkg::KIND_SINGLE: begin
        single = 1'b1;
      end
      fmt_pkg::KIND_RAMP: begin
        if (pa <= pb) begin
          hi      = pb;
          rise_en = 1'b1;
          brk1    = '1;
        end else begin
          lo       = pb;
          hi       = pa;
          fall_den = pa - pb;
        end
      end
      fmt_pkg::KIND_TRI: begin
        hi      = pc;
        rise_en = 1'b1;
      end
      fmt_pkg::KIND_TRAP: begin
        hi       = pd;
        rise_en  = 1'b1;
        flat_en  = 1'b1;
        pivot    = pc;
        fall_den = pd - pc;
      end
      default: begin
        single = 1'b0;
      end
    endcase
    hsat = (ht > fmt_pkg::ONE) ? fmt_pkg::ONE : ht;
  end

  // shared divider for the per-point step of each segment
  fmt_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .den   (cmd.div_fall ? fall_den : rise_den),
    .done  (div_done),
    .quo   (div_quo),
    .rmd   (div_rmd)
  );

  always_ff @(posedge clk) begin
    if (cmd.div_cap_rise) begin
      rise_q <= div_quo;
      rise_r <= div_rmd;
    end
    if (cmd.div_cap_fall) begin
      fall_q <= div_quo;
      fall_r <= div_rmd;
    end
  end

  // point value from the running quotients
  always_comb begin
    x8   = PW'(x);
    xn   = {1'b0, x8} + 9'd1;
    rsum = {1'b0, rr} + {1'b0, rise_r};
    fsum = {1'b0, fr} + {1'b0, fall_den} - {1'b0, fall_r};
    val  = '0;
    if (single) begin
      val = (x8 == pa) ? hsat : '0;
    end else if (x8 >= lo && x8 <= hi) begin
      if (rise_en && x8 <= brk1) begin
        val = (rise_den == '0) ? fmt_pkg::ONE : rq;
      end else if (flat_en && x8 <= brk2) begin
        val = fmt_pkg::ONE;
      end else begin
        val = (fall_den == '0) ? fmt_pkg::ONE : fq;
      end
    end
  end

  // advance sweep: rising quotient counts up, falling one counts down
  always_ff @(posedge clk) begin
    if (cmd.sweep_init) begin
      x  <= '0;
      rq <= '0;
      rr <= '0;
      fq <= fmt_pkg::ONE;
      fr <= '0;
    end else if (cmd.sweep_step) begin
      x <= x + XW'(1);
      if (xn == {1'b0, pa}) begin
        rq <= '0;
        rr <= '0;
      end else if (rsum >= {1'b0, rise_den}) begin
        rr <= 8'(rsum - {1'b0, rise_den});
        rq <= rq + rise_q + 9'd1;
      end else begin
        rr <= rsum[PW-1:0];
        rq <= rq + rise_q;
      end
      if (xn == {1'b0, pivot}) begin
        fq <= fmt_pkg::ONE;
        fr <= '0;
      end else if (fr >= fall_r) begin
        fr <= fr - fall_r;
        fq <= fq - fall_q;
      end else begin
        fr <= fsum[PW-1:0];
        fq <= fq - fall_q - 9'd1;
      end
    end
  end

  // membership RAM
  assign wcat  = {row, x};
  assign rcat  = {k, qx[XW-1:0]};
  assign qx_in = {1'b0, qx} < 9'(SPAN);

  fmt_ram #(
    .WIDTH (VW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.sweep_step),
    .waddr (wcat[AW-1:0]),
    .wdata (val),
    .re    (cmd.rd_issue),
    .raddr (rcat[AW-1:0]),
    .rdata (rdata)
  );

  // row allocation and valid marks
  always_ff @(posedge clk) begin
    if (rst) begin
      next_row  <= '0;
      row_valid <= '0;
    end else if (cmd.row_commit) begin
      next_row       <= next_row + NRW'(1);
      row_valid[row] <= 1'b1;
    end
  end

  // query row counter
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      k <= '0;
    end else if (cmd.k_step) begin
      k <= k + RW'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_st <= cmd.out_status;
      case (cmd.out_status)
        fmt_pkg::STAT_QUERY: begin
          o_ti   <= fmt_pkg::TI_W'(k);
          o_mem  <= (row_valid[k] && qx_in) ? rdata : '0;
          o_last <= sts.k_last;
        end
        fmt_pkg::STAT_ADDED: begin
          o_ti   <= fmt_pkg::TI_W'(row);
          o_mem  <= '0;
          o_last <= 1'b1;
        end
        default: begin
          o_ti   <= '0;
          o_mem  <= '0;
          o_last <= 1'b1;
        end
      endcase
    end
  end

  assign out_data = {3'b000, o_st, o_mem, o_ti};
  assign out_last = o_last;

  // status to the controller
  always_comb begin
    sts.mode     = mode;
    sts.kind_ok  = (kind >= fmt_pkg::KIND_SINGLE) && (kind <= fmt_pkg::KIND_TRAP);
    sts.full     = next_row >= NRW'(TERMS);
    sts.div_done = div_done;
    sts.x_last   = x == XW'(SPAN - 1);
    sts.k_last   = k == RW'(TERMS - 1);
    sts.out_free = !out_valid || out_ready;
  end

endmodule

// ----- rtl/fmt_ctrl.sv -----
// ----------------------------------------------------------------------------
// fmt_ctrl
// Sequencer for add and query items of the membership table.
// ----------------------------------------------------------------------------
module fmt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fmt_pkg::fmt_sts_t  sts,
  output fmt_pkg::fmt_cmd_t  cmd
);

  fmt_pkg::fsm_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fmt_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      fmt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = fmt_pkg::ST_DECODE;
        end
      end
      fmt_pkg::ST_DECODE: begin
        if (sts.mode == fmt_pkg::MODE_QUERY) begin
          state_next = fmt_pkg::ST_Q_RD;
        end else if (!sts.kind_ok) begin
          state_next = fmt_pkg::ST_IDLE;
        end else if (sts.full) begin
          state_next = fmt_pkg::ST_FULL_RES;
        end else begin
          state_next = fmt_pkg::ST_DIVR_GO;
        end
      end
      fmt_pkg::ST_DIVR_GO: begin
        cmd.div_start = 1'b1;
        state_next    = fmt_pkg::ST_DIVR_WAIT;
      end
      fmt_pkg::ST_DIVR_WAIT: begin
        if (sts.div_done) begin
          cmd.div_cap_rise = 1'b1;
          state_next       = fmt_pkg::ST_DIVF_GO;
        end
      end
      fmt_pkg::ST_DIVF_GO: begin
        cmd.div_start = 1'b1;
        cmd.div_fall  = 1'b1;
        state_next    = fmt_pkg::ST_DIVF_WAIT;
      end
      fmt_pkg::ST_DIVF_WAIT: begin
        if (sts.div_done) begin
          cmd.div_cap_fall = 1'b1;
          cmd.sweep_init   = 1'b1;
          state_next       = fmt_pkg::ST_SWEEP;
        end
      end
      fmt_pkg::ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.x_last) begin
          state_next = fmt_pkg::ST_ADD_RES;
        end
      end
      fmt_pkg::ST_ADD_RES: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = fmt_pkg::STAT_ADDED;
          cmd.row_commit = 1'b1;
          state_next     = fmt_pkg::ST_IDLE;
        end
      end
      fmt_pkg::ST_FULL_RES: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = fmt_pkg::STAT_FULL;
          state_next     = fmt_pkg::ST_IDLE;
        end
      end
      fmt_pkg::ST_Q_RD: begin
        cmd.rd_issue = 1'b1;
        state_next   = fmt_pkg::ST_Q_OUT;
      end
      fmt_pkg::ST_Q_OUT: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = fmt_pkg::STAT_QUERY;
          if (sts.k_last) begin
            state_next = fmt_pkg::ST_IDLE;
          end else begin
            cmd.k_step = 1'b1;
            state_next = fmt_pkg::ST_Q_RD;
          end
        end
      end
      default: begin
        state_next = fmt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/fuzzy_membership_table_top.sv -----
// ----------------------------------------------------------------------------
// fuzzy_membership_table_top
// Membership table fuzzifier: rasterizes terms into rows, reads them at x.
//
//   channel   dir  fields
//   s_axis    in   tuser: mode, term_kind; tdata: point_a..d, height, query_x
//   m_axis    out  tdata: term_index, membership, status; tlast: last
//
// From the accept, an add runs two nine-step divisions on the shared divider,
// then one RAM write per point of the universe (at most 256 points).
// A query does one RAM read and one result per row.
// Reset clears the row count and the per-row valid bits; a row never added
// reads as zero and an added row is rewritten in full, so no clearing pass.
// One item is in work at a time; a held result stalls only the next result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fuzzy_membership_table_top #(
  parameter int TERMS    = 4,
  parameter int UNIVERSE = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [7:0] point_a, [15:8] point_b, [23:16] point_c, [31:24] point_d,
  // [40:32] height, [48:41] query_x, [55:49] zero
  input  logic [fmt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] mode, [3:1] term_kind
  input  logic [fmt_pkg::IN_USER_W-1:0]  s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] term_index, [10:2] membership, [12:11] status, [15:13] zero
  output logic [fmt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                           m_axis_tlast
);

  fmt_pkg::fmt_cmd_t cmd;
  fmt_pkg::fmt_sts_t sts;

  fmt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  fmt_datapath #(
    .TERMS    (TERMS),
    .UNIVERSE (UNIVERSE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_axis_tdata),
    .in_user   (s_axis_tuser),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  // checks
  `ASSERT_NXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "accept while busy")
  `ASSERT_IMP(a_no_overwrite, cmd.out_load, sts.out_free, "result overwritten")
  `ASSERT_IMP(a_row_bound, cmd.row_commit || cmd.sweep_step, !sts.full, "row past table")

endmodule

// ----- verif/fuzzy_membership_table_checker.sv -----
// ----------------------------------------------------------------------------
// fuzzy_membership_table_checker
// Watches both stream channels of the membership table. It keeps its own copy
// of the term rows, works out the results of every accepted input transaction
// and compares each output transaction, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module fuzzy_membership_table_checker #(
  parameter int TERMS    = 4,
  parameter int UNIVERSE = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  // [7:0] point_a, [15:8] point_b, [23:16] point_c, [31:24] point_d,
  // [40:32] height, [48:41] query_x, [55:49] zero
  input  logic [fmt_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // [0] mode, [3:1] term_kind
  input  logic [fmt_pkg::IN_USER_W-1:0]  s_axis_tuser,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [1:0] term_index, [10:2] membership, [12:11] status, [15:13] zero
  input  logic [fmt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                           m_axis_tlast,
  output int                             fail_count,
  output int                             results_pending
);
  import fmt_pkg::*;

  typedef struct packed {
    logic [TI_W-1:0]   term_index;
    logic [VAL_W-1:0]  membership;
    logic [STAT_W-1:0] status;
    logic              last;
  } fuzz_result_t;

  logic [VAL_W-1:0] member_tbl [TERMS][UNIVERSE];
  int               rows_used;
  int               mismatch_total;
  fuzz_result_t     expected_results [$];

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_total++;
  endtask

  // (num * 1.0) / den, truncated; a zero span is full membership
  function automatic logic [VAL_W-1:0] scaled_ratio(input int num, input int den);
    if (den == 0) return ONE;
    return VAL_W'((num * int'(ONE)) / den);
  endfunction

  task automatic store_entry(input int row, input int x, input logic [VAL_W-1:0] v);
    if (x < UNIVERSE) member_tbl[row][x] = v;
  endtask

  // Queue the results of one input transaction and update the rows
  task automatic predict_item(input logic [IN_USER_W-1:0] user,
                              input logic [IN_DATA_W-1:0] data);
    logic [KIND_W-1:0] kind;
    fuzz_result_t      res;
    int                a, b, c, d, h, qx;
    kind = user[KIND_W:1];
    a    = data[7:0];
    b    = data[15:8];
    c    = data[23:16];
    d    = data[31:24];
    h    = data[40:32];
    qx   = data[48:41];

    // Report every row at the query point
    if (user[0] == MODE_QUERY) begin
      for (int k = 0; k < TERMS; k++) begin
        res.term_index = TI_W'(k);
        res.membership = (qx < UNIVERSE) ? member_tbl[k][qx] : '0;
        res.status     = STAT_QUERY;
        res.last       = (k == TERMS - 1);
        expected_results.push_back(res);
      end
      return;
    end

    // Drop adds of no known kind silently
    if (!(kind inside {KIND_SINGLE, KIND_RAMP, KIND_TRI, KIND_TRAP})) return;

    res.membership = '0;
    res.last       = 1'b1;
    if (rows_used >= TERMS) begin
      res.term_index = '0;
      res.status     = STAT_FULL;
      expected_results.push_back(res);
      return;
    end

    // Rasterize the term into the next free row
    case (kind)
      KIND_SINGLE: store_entry(rows_used, a, (h > int'(ONE)) ? ONE : VAL_W'(h));
      KIND_RAMP: begin
        if (a <= b) begin
          for (int i = a; i <= b; i++) store_entry(rows_used, i, scaled_ratio(i - a, b - a));
        end else begin
          for (int i = b; i <= a; i++) store_entry(rows_used, i, scaled_ratio(a - i, a - b));
        end
      end
      KIND_TRI: begin
        for (int i = a; i <= c; i++) begin
          if (i <= b) store_entry(rows_used, i, scaled_ratio(i - a, b - a));
          else        store_entry(rows_used, i, scaled_ratio(c - i, c - b));
        end
      end
      KIND_TRAP: begin
        for (int i = a; i <= d; i++) begin
          if (i <= b)      store_entry(rows_used, i, scaled_ratio(i - a, b - a));
          else if (i <= c) store_entry(rows_used, i, ONE);
          else             store_entry(rows_used, i, scaled_ratio(d - i, d - c));
        end
      end
      default: ;
    endcase
    res.term_index = TI_W'(rows_used);
    res.status     = STAT_ADDED;
    expected_results.push_back(res);
    rows_used++;
  endtask

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    fuzz_result_t want;
    if (rst) begin
      foreach (member_tbl[r, x]) member_tbl[r][x] = '0;
      rows_used      = 0;
      mismatch_total = 0;
      expected_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) predict_item(s_axis_tuser, s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected, tdata %h", m_axis_tdata));
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tdata[1:0] != want.term_index)
            report_mismatch($sformatf("term_index got %0d want %0d",
                                      m_axis_tdata[1:0], want.term_index));
          if (m_axis_tdata[10:2] != want.membership)
            report_mismatch($sformatf("row %0d membership got %0d want %0d",
                                      want.term_index, m_axis_tdata[10:2], want.membership));
          if (m_axis_tdata[12:11] != want.status)
            report_mismatch($sformatf("row %0d status got %0d want %0d",
                                      want.term_index, m_axis_tdata[12:11], want.status));
          if (m_axis_tlast != want.last)
            report_mismatch($sformatf("row %0d last got %0b want %0b",
                                      want.term_index, m_axis_tlast, want.last));
        end
      end
    end
    fail_count      <= mismatch_total;
    results_pending <= expected_results.size();
  end

endmodule

// ----- verif/fuzzy_membership_table_top_tb.sv -----
// ----------------------------------------------------------------------------
// fuzzy_membership_table_top_tb
// Drives adds and queries into the membership table with random idle bursts
// on both channels; the checker predicts and compares every result. A short
// directed part fills all rows and hits the edge cases, then random traffic
// follows, mostly queries at random points plus adds against a full table.
// ----------------------------------------------------------------------------
module fuzzy_membership_table_top_tb;
  import fmt_pkg::*;

  localparam int TERMS         = 4;
  localparam int UNIVERSE      = 256;
  localparam int RANDOM_ITEMS  = 340;
  localparam int CALM_ITEMS    = 60;
  localparam int SETTLE_CYCLES = 400;
  localparam int CYCLE_LIMIT   = 400000;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  idle_en       = 1'b1;
  int                    stall_left    = 0;
  int                    cycle_count   = 0;
  int                    fail_count;
  int                    results_pending;

  fuzzy_membership_table_top #(
    .TERMS    (TERMS),
    .UNIVERSE (UNIVERSE)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  fuzzy_membership_table_checker #(
    .TERMS    (TERMS),
    .UNIVERSE (UNIVERSE)
  ) u_checker (
    .clk             (clk),
    .rst             (rst),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .s_axis_tdata    (s_axis_tdata),
    .s_axis_tuser    (s_axis_tuser),
    .m_axis_tvalid   (m_axis_tvalid),
    .m_axis_tready   (m_axis_tready),
    .m_axis_tdata    (m_axis_tdata),
    .m_axis_tlast    (m_axis_tlast),
    .fail_count      (fail_count),
    .results_pending (results_pending)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Stall the result channel in random bursts
  always @(posedge clk) begin
    if (rst || !idle_en) begin
      m_axis_tready <= 1'b1;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= (stall_left == 1);
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(1, 13);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // End the run if it hangs
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL fuzzy_membership_table_top");
    $finish;
  end

  function automatic logic [IN_DATA_W-1:0] pack_fields(input int a, input int b, input int c,
                                                       input int d, input int h, input int qx);
    return {7'd0, 8'(qx), 9'(h), 8'(d), 8'(c), 8'(b), 8'(a)};
  endfunction

  // Present one transaction and hold it until accepted; valid stays high
  // into the next transaction unless an idle burst comes first
  task automatic send_item(input logic [IN_USER_W-1:0] user,
                           input logic [IN_DATA_W-1:0] data);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= user;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  // Query with random junk in the fields a query ignores
  task automatic send_query(input int x);
    send_item({KIND_W'($urandom), MODE_QUERY},
              pack_fields($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 511), x));
  endtask

  task automatic send_add(input logic [KIND_W-1:0] kind, input int a, input int b,
                          input int c, input int d, input int h);
    send_item({kind, MODE_ADD}, pack_fields(a, b, c, d, h, $urandom_range(0, 255)));
  endtask

  initial begin
    int spot;
    spot = $urandom_range(0, 255);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, then fill every row
    send_query(0);
    // trapezoid with a zero-span rising edge, plateau, falling to the top point
    send_add(KIND_TRAP, 0, 0, 70, 255, 0);
    // falling ramp over the whole universe
    send_add(KIND_RAMP, 255, 0, 0, 0, 0);
    send_add(KIND_TRI, 20, 90, 180, 0, 0);
    // last row: singleton above one, rising ramp, or an empty-range term
    case ($urandom_range(0, 3))
      0:       send_add(KIND_SINGLE, spot, 0, 0, 0, $urandom_range(257, 511));
      1:       send_add(KIND_RAMP, 30, 200, 0, 0, 0);
      2:       send_add(KIND_TRI, 200, 150, 100, 0, 0);
      default: send_add(KIND_TRAP, 220, 230, 240, 10, 0);
    endcase
    // table is full now
    send_add(KIND_SINGLE, 5, 0, 0, 0, 511);
    send_add(KIND_RAMP, 10, 100, 0, 0, 0);
    send_add(KIND_TRAP, 1, 2, 3, 4, 0);
    // kinds that cause no result
    send_add(KIND_NONE, 7, 8, 9, 10, 256);
    send_add(KIND_W'(5), 0, 255, 0, 255, 0);
    send_add(KIND_W'(6), 255, 0, 255, 0, 511);
    send_add(KIND_W'(7), 128, 128, 128, 128, 128);
    send_query(0);
    send_query(1);
    send_query(30);
    send_query(70);
    send_query(71);
    send_query(128);
    send_query(180);
    send_query(254);
    send_query(255);
    send_query(spot);

    // Random: mostly queries, some adds of any kind against the full table
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_en <= 1'b0;
      if ($urandom_range(0, 9) < 2) begin
        send_add(KIND_W'($urandom_range(0, 7)), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 255),
                 $urandom_range(0, 255), $urandom_range(0, 511));
      end else begin
        send_query($urandom_range(0, 255));
      end
    end
    s_axis_tvalid <= 1'b0;

    // Drain the expected results, then give stray ones time to show up
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS fuzzy_membership_table_top");
    end else begin
      $display("FAIL fuzzy_membership_table_top");
    end
    $finish;
  end

endmodule
